>>> design/cbm_pkg.sv
package cbm_pkg;

   localparam int PageWidth  = 9;
   localparam int CountWidth = 10;
   localparam int BankCount  = 8;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_PRG   = 2'd2;
   localparam logic [1:0] MODE_CHR   = 2'd3;

   localparam logic [15:0] ADDR_PRG_16K  = 16'h8000;
   localparam logic [15:0] ADDR_MIRROR   = 16'hB003;
   localparam logic [15:0] ADDR_PRG_C000 = 16'hC000;
   localparam logic [15:0] ADDR_CHR_LO   = 16'hD000;
   localparam logic [15:0] ADDR_CHR_HI   = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_LAT  = 16'hF000;
   localparam logic [15:0] ADDR_IRQ_CTL  = 16'hF001;
   localparam logic [15:0] ADDR_IRQ_ACK  = 16'hF002;
   localparam logic [15:0] ADDR_PRG_BASE = 16'h8000;
   localparam logic [15:0] ADDR_CHR_END  = 16'h2000;

   localparam logic [7:0] IRQ_COUNT_TOP = 8'hFF;
   localparam logic [7:0] MIRROR_MASK   = 8'h0C;

   localparam logic [CountWidth-1:0] PAGE_COUNT_RESET = 10'd16;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_word_type;

   typedef struct packed {
      logic [PageWidth-1:0] page_number;
      logic [1:0]           mirroring;
      logic                 irq_fire;
   } rsp_word_type;

endpackage

>>> design/cartridge_bank_mapper_with_scanline_irq.sv
// Cartridge bank mapper with a scanline interrupt counter.
// Request channel (req_valid, req_stall, req_word): each word is a register
// write, a scanline tick, a program page query or a character page query.
// Response channel (rsp_valid, rsp_stall, rsp_word): exactly one word per
// request, in order, carrying the page number, the mirroring mode after the
// request and the interrupt pulse for a tick.
// Register port (csr_valid, csr_ready, csr_data): sets the program page
// count; csr_ready is always high. Write it only while the block is idle.
// A response is registered before it is valid on the response channel.
// Throughput: one request per cycle while req_stall is low; all decode and
// lookup is combinational from the bank registers to the response register.
// When the receiver stalls, the response register holds its word and one
// more request is caught in a skid register; req_stall rises only while
// that skid register is full.
// Reset: bank registers, mirroring and interrupt state return to their
// power-on values, the page count returns to 16, and both channels empty.
module cartridge_bank_mapper_with_scanline_irq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cbm_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cbm_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbm_pkg::CountWidth-1:0]  csr_data
);
   import cbm_pkg::*;

   logic [CountWidth-1:0] page_count_ff;
   rsp_word_type          out_ff;
   logic                  out_valid_ff;
   rsp_word_type          skid_ff;
   logic                  skid_valid_ff;
   rsp_word_type          result;
   logic                  accept;
   logic                  take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   cbm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (req_word),
      .page_count (page_count_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGE_COUNT_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            page_count_ff <= csr_data;
         end
         if (take || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= result;
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

>>> design/cbm_core.sv
module cbm_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  cbm_pkg::req_word_type           item,
   input  logic [cbm_pkg::CountWidth-1:0]  page_count,
   output cbm_pkg::rsp_word_type           result
);
   import cbm_pkg::*;

   localparam logic [CountWidth-1:0] PrgC000Reset = PAGE_COUNT_RESET - 10'd2;

   logic [7:0]           prg_16k_ff,   prg_16k_in;
   logic [PageWidth-1:0] prg_c000_ff,  prg_c000_in;
   logic [7:0]           chr_bank_ff [BankCount];
   logic [7:0]           chr_bank_in [BankCount];
   logic [1:0]           mirror_ff,    mirror_in;
   logic [7:0]           irq_latch_ff, irq_latch_in;
   logic [7:0]           irq_count_ff, irq_count_in;
   logic                 irq_en_ff,    irq_en_in;
   logic                 irq_act_ff,   irq_act_in;

   logic [PageWidth-1:0] page;
   logic [PageWidth-1:0] last_page;
   logic [7:0]           mirror_bits;
   logic                 fire;

   assign last_page   = PageWidth'(page_count - 10'd1);
   assign mirror_bits = item.write_data & MIRROR_MASK;

   always_comb begin
      prg_16k_in   = prg_16k_ff;
      prg_c000_in  = prg_c000_ff;
      chr_bank_in  = chr_bank_ff;
      mirror_in    = mirror_ff;
      irq_latch_in = irq_latch_ff;
      irq_count_in = irq_count_ff;
      irq_en_in    = irq_en_ff;
      irq_act_in   = irq_act_ff;
      page         = '0;
      fire         = 1'b0;
      case (item.mode)
         MODE_WRITE: begin
            if (item.address == ADDR_PRG_16K) begin
               prg_16k_in = item.write_data;
            end else if (item.address == ADDR_MIRROR) begin
               mirror_in = mirror_bits[3:2];
            end else if (item.address == ADDR_PRG_C000) begin
               prg_c000_in = {1'b0, item.write_data};
            end else if (item.address[15:2] == ADDR_CHR_LO[15:2]) begin
               chr_bank_in[{1'b0, item.address[1:0]}] = item.write_data;
            end else if (item.address[15:2] == ADDR_CHR_HI[15:2]) begin
               chr_bank_in[{1'b1, item.address[1:0]}] = item.write_data;
            end else if (item.address == ADDR_IRQ_LAT) begin
               irq_latch_in = item.write_data;
            end else if (item.address == ADDR_IRQ_CTL) begin
               irq_en_in  = item.write_data[0];
               irq_act_in = item.write_data[1];
               if (item.write_data[1]) begin
                  irq_count_in = irq_latch_ff;
               end
            end else if (item.address == ADDR_IRQ_ACK) begin
               irq_act_in = irq_en_ff;
            end
         end
         MODE_TICK: begin
            if (irq_act_ff) begin
               if (irq_count_ff == IRQ_COUNT_TOP) begin
                  fire         = 1'b1;
                  irq_count_in = irq_latch_ff;
               end else begin
                  irq_count_in = irq_count_ff + 8'd1;
               end
            end
         end
         MODE_PRG: begin
            if (item.address >= ADDR_PRG_BASE) begin
               case (item.address[14:13])
                  2'd0:    page = {prg_16k_ff, 1'b0};
                  2'd1:    page = {prg_16k_ff, 1'b1};
                  2'd2:    page = prg_c000_ff;
                  default: page = last_page;
               endcase
            end
         end
         default: begin
            if (item.address < ADDR_CHR_END) begin
               page = {1'b0, chr_bank_ff[item.address[12:10]]};
            end
         end
      endcase
   end

   assign result.page_number = page;
   assign result.mirroring   = mirror_in;
   assign result.irq_fire    = fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_16k_ff   <= '0;
         prg_c000_ff  <= PageWidth'(PrgC000Reset);
         for (int i = 0; i < BankCount; i++) begin
            chr_bank_ff[i] <= 8'(i);
         end
         mirror_ff    <= '0;
         irq_latch_ff <= '0;
         irq_count_ff <= '0;
         irq_en_ff    <= 1'b0;
         irq_act_ff   <= 1'b0;
      end else if (accept) begin
         prg_16k_ff   <= prg_16k_in;
         prg_c000_ff  <= prg_c000_in;
         chr_bank_ff  <= chr_bank_in;
         mirror_ff    <= mirror_in;
         irq_latch_ff <= irq_latch_in;
         irq_count_ff <= irq_count_in;
         irq_en_ff    <= irq_en_in;
         irq_act_ff   <= irq_act_in;
      end
   end

endmodule

>>> dv/tb_cartridge_bank_mapper_with_scanline_irq.sv
module tb_cartridge_bank_mapper_with_scanline_irq;
   timeunit 1ns;
   timeprecision 1ps;

   import cbm_pkg::*;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CountWidth-1:0] csr_data = '0;

   // mapper state as the block should hold it
   logic [7:0]            prg_bank_16k;
   logic [PageWidth-1:0]  prg_bank_c000;
   logic [7:0]            chr_bank [BankCount];
   logic [1:0]            mirror_mode;
   logic [7:0]            irq_latch;
   logic [7:0]            irq_counter;
   logic                  irq_enable_on_ack;
   logic                  irq_running;
   logic [CountWidth-1:0] page_count;
   logic [CountWidth-1:0] count_less_two;

   req_word_type          pending_reqs[$];
   rsp_word_type          expected_words[$];

   bit                    req_taken = 1'b0;
   bit                    csr_taken = 1'b0;
   bit                    driving = 1'b0;
   int unsigned           gap_left = 0;
   int unsigned           gap_calm = 0;
   int unsigned           stall_left = 0;
   int unsigned           stall_calm = 0;
   int unsigned           errors = 0;
   int unsigned           n_reqs = 0;
   int unsigned           n_rsps = 0;
   int unsigned           n_fires = 0;
   int unsigned           n_settings = 1;

   cartridge_bank_mapper_with_scanline_irq u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic rsp_word_type map_request(input req_word_type w);
      rsp_word_type          r;
      logic [CountWidth-1:0] last_page;
      r = '0;
      case (w.mode)
         MODE_WRITE: begin
            if (w.address == ADDR_PRG_16K) begin
               prg_bank_16k = w.write_data;
            end else if (w.address == ADDR_MIRROR) begin
               mirror_mode = w.write_data[3:2];
            end else if (w.address == ADDR_PRG_C000) begin
               prg_bank_c000 = {1'b0, w.write_data};
            end else if (w.address[15:2] == ADDR_CHR_LO[15:2]) begin
               chr_bank[{1'b0, w.address[1:0]}] = w.write_data;
            end else if (w.address[15:2] == ADDR_CHR_HI[15:2]) begin
               chr_bank[{1'b1, w.address[1:0]}] = w.write_data;
            end else if (w.address == ADDR_IRQ_LAT) begin
               irq_latch = w.write_data;
            end else if (w.address == ADDR_IRQ_CTL) begin
               irq_enable_on_ack = w.write_data[0];
               irq_running = w.write_data[1];
               if (w.write_data[1]) irq_counter = irq_latch;
            end else if (w.address == ADDR_IRQ_ACK) begin
               irq_running = irq_enable_on_ack;
            end
         end
         MODE_TICK: begin
            if (irq_running) begin
               if (irq_counter == IRQ_COUNT_TOP) begin
                  r.irq_fire = 1'b1;
                  irq_counter = irq_latch;
               end else begin
                  irq_counter = irq_counter + 8'd1;
               end
            end
         end
         MODE_PRG: begin
            if (w.address >= ADDR_PRG_BASE) begin
               last_page = page_count - 10'd1;
               case (w.address[14:13])
                  2'd0: r.page_number = {prg_bank_16k, 1'b0};
                  2'd1: r.page_number = {prg_bank_16k, 1'b1};
                  2'd2: r.page_number = prg_bank_c000;
                  default: r.page_number = last_page[PageWidth-1:0];
               endcase
            end
         end
         default: begin
            if (w.address < ADDR_CHR_END) r.page_number = {1'b0, chr_bank[w.address[12:10]]};
         end
      endcase
      r.mirroring = mirror_mode;
      return r;
   endfunction

   function automatic int unsigned pick_idle(inout int unsigned calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm != 0) begin
         calm = calm - 1;
         return 0;
      end
      if (roll < 2) begin
         calm = $urandom_range(30, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) driving = 1'b0;
         if (!driving) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
               req_word <= pending_reqs.pop_front();
               driving = 1'b1;
               gap_left = pick_idle(gap_calm);
            end
         end
         req_valid <= driving;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left != 0) stall_left = stall_left - 1;
         else if ($urandom_range(0, 3) == 0) stall_left = pick_idle(stall_calm);
         rsp_stall <= (stall_left != 0);
      end
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      rsp_word_type want;
      req_taken = 1'b0;
      if (reset) begin
         page_count = PAGE_COUNT_RESET;
         count_less_two = PAGE_COUNT_RESET - 10'd2;
         prg_bank_16k = '0;
         prg_bank_c000 = count_less_two[PageWidth-1:0];
         for (int i = 0; i < BankCount; i++) chr_bank[i] = 8'(i);
         mirror_mode = '0;
         irq_latch = '0;
         irq_counter = '0;
         irq_enable_on_ack = 1'b0;
         irq_running = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_rsps++;
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected word page %0d mirror %0d irq %0b", $time,
                           rsp_word.page_number, rsp_word.mirroring, rsp_word.irq_fire);
            end else begin
               want = expected_words.pop_front();
               if (want.irq_fire) n_fires++;
               if (rsp_word.page_number != want.page_number ||
                   rsp_word.mirroring != want.mirroring ||
                   rsp_word.irq_fire != want.irq_fire) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch expected page %0d mirror %0d irq %0b, got %0d %0d %0b",
                              $time, want.page_number, want.mirroring, want.irq_fire,
                              rsp_word.page_number, rsp_word.mirroring, rsp_word.irq_fire);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            page_count = csr_data;
            csr_taken = 1'b1;
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(map_request(req_word));
            req_taken = 1'b1;
            n_reqs++;
         end
      end
   end

   task automatic push_req(input logic [1:0] mode, input logic [15:0] address,
                           input logic [7:0] write_data);
      req_word_type w;
      w.mode = mode;
      w.address = address;
      w.write_data = write_data;
      pending_reqs.push_back(w);
   endtask

   task automatic push_random(input int unsigned count);
      req_word_type w;
      int unsigned  roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         w.address = 16'($urandom);
         w.write_data = 8'($urandom);
         if (roll < 30) begin
            w.mode = MODE_TICK;
         end else if (roll < 45) begin
            w.mode = MODE_PRG;
            if ($urandom_range(0, 4) != 0) w.address[15] = 1'b1;
         end else if (roll < 60) begin
            w.mode = MODE_CHR;
            if ($urandom_range(0, 4) != 0) w.address[15:13] = 3'b000;
         end else begin
            w.mode = MODE_WRITE;
            case ($urandom_range(0, 10))
               0: w.address = ADDR_PRG_16K;
               1: w.address = ADDR_MIRROR;
               2: w.address = ADDR_PRG_C000;
               3: w.address = ADDR_CHR_LO | 16'($urandom_range(0, 3));
               4: w.address = ADDR_CHR_HI | 16'($urandom_range(0, 3));
               5: begin
                  w.address = ADDR_IRQ_LAT;
                  if ($urandom_range(0, 2) != 0) w.write_data = 8'($urandom_range(8'hE0, 8'hFF));
               end
               6, 7: w.address = ADDR_IRQ_CTL;
               8: w.address = ADDR_IRQ_ACK;
               9: ;
               default: w.address = ADDR_IRQ_CTL ^ (16'd1 << $urandom_range(0, 15));
            endcase
         end
         pending_reqs.push_back(w);
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || driving || expected_words.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      logic [CountWidth-1:0] page_counts [7];
      page_counts = '{10'd2, 10'd512, 10'd0, 10'd1023, 10'd1, 10'd16, 10'd16};
      page_counts[6] = CountWidth'($urandom_range(3, 511));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_req(MODE_PRG, 16'h0000, 8'h00);
      push_req(MODE_PRG, 16'h7FFF, 8'hFF);
      push_req(MODE_PRG, 16'h8000, 8'h00);
      push_req(MODE_PRG, 16'hA000, 8'h00);
      push_req(MODE_PRG, 16'hC000, 8'h00);
      push_req(MODE_PRG, 16'hFFFF, 8'h00);
      push_req(MODE_CHR, 16'h0000, 8'h00);
      push_req(MODE_CHR, 16'h1FFF, 8'h00);
      push_req(MODE_CHR, 16'h2000, 8'h00);
      push_req(MODE_CHR, 16'hFFFF, 8'h00);
      push_req(MODE_WRITE, ADDR_PRG_16K, 8'hFF);
      push_req(MODE_WRITE, ADDR_PRG_C000, 8'hFF);
      push_req(MODE_WRITE, ADDR_CHR_LO + 16'd3, 8'hAA);
      push_req(MODE_WRITE, ADDR_CHR_HI, 8'h55);
      push_req(MODE_WRITE, ADDR_PRG_16K + 16'd1, 8'h12);
      push_req(MODE_WRITE, ADDR_MIRROR, 8'h0C);
      push_req(MODE_PRG, 16'hA000, 8'h00);
      push_req(MODE_CHR, 16'h0C00, 8'h00);
      push_req(MODE_WRITE, ADDR_IRQ_LAT, 8'hFE);
      push_req(MODE_WRITE, ADDR_IRQ_CTL, 8'h03);
      push_req(MODE_TICK, 16'h0000, 8'h00);
      push_req(MODE_TICK, 16'hFFFF, 8'hFF);
      push_req(MODE_WRITE, ADDR_IRQ_ACK, 8'h00);
      push_req(MODE_WRITE, ADDR_IRQ_CTL, 8'h00);
      push_req(MODE_TICK, 16'h0000, 8'h00);
      push_req(MODE_WRITE, ADDR_MIRROR, 8'hF3);
      push_random(100);
      wait_idle();

      foreach (page_counts[k]) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_data <= page_counts[k];
         csr_taken = 1'b0;
         do @(negedge clock); while (!csr_taken);
         csr_valid <= 1'b0;
         n_settings++;
         push_req(MODE_PRG, 16'hE000, 8'h00);
         push_req(MODE_PRG, 16'hFFFF, 8'h00);
         push_req(MODE_PRG, 16'hC000, 8'h00);
         push_random(100);
         wait_idle();
      end

      $display("%0d words sent over %0d page-count settings, %0d responses checked",
               n_reqs, n_settings, n_rsps);
      $display("%0d interrupt pulses predicted, %0d mismatches", n_fires, errors);
      if (errors == 0) begin
         $display("tb_cartridge_bank_mapper_with_scanline_irq passed");
      end else begin
         $display("tb_cartridge_bank_mapper_with_scanline_irq failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_cartridge_bank_mapper_with_scanline_irq failed");
      $finish;
   end

endmodule

>>> sim.f
design/cbm_pkg.sv
design/cbm_core.sv
design/cartridge_bank_mapper_with_scanline_irq.sv
dv/tb_cartridge_bank_mapper_with_scanline_irq.sv
